// ----- rtl/modbus_request_hex_framer_assert.svh -----
// Assertion macros used by the framer queue RTL.
`ifndef MODBUS_REQUEST_HEX_FRAMER_ASSERT_SVH
`define MODBUS_REQUEST_HEX_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define MRHF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("framer assertion failed");
`define MRHF_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("framer forbidden condition");
`else
`define MRHF_ASSERT(label, clk, rstn, prop)
`define MRHF_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

// ----- rtl/mrhf_pkg.sv -----
// Types, constants and helper functions of the Modbus request hex framer.
package mrhf_pkg;

    localparam int unsigned FRAME_W       = 64;
    localparam int unsigned HDR_W         = 48;
    localparam int unsigned CRC_BYTES     = 6;
    localparam int unsigned STEP_W        = 3;
    localparam int unsigned FRAME_CHARS   = 16;
    localparam int unsigned CHAR_IDX_W    = 4;
    localparam int unsigned QUEUE_DEPTH_D = 2;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h11;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CRC,
        FR_PUSH
    } front_state_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [6:0] nibble_ascii(input logic [3:0] nib);
        logic [6:0] ch;
        if (nib < 4'd10) begin
            ch = 7'h30 + {3'b000, nib};
        end else begin
            ch = 7'h37 + {3'b000, nib};
        end
        return ch;
    endfunction

endpackage

// ----- rtl/mrhf_front.sv -----
// Front end: accepts a request, builds the header bytes and runs the CRC.
module mrhf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          slave_address,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [15:0]         s_start_address,
    input  logic [15:0]         s_data_word,
    output logic                push_valid,
    input  logic                push_ready,
    output mrhf_pkg::frame_t    push_frame
);
    import mrhf_pkg::*;

    front_state_t     state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [HDR_W-1:0]  hdr_reg;
    logic [HDR_W-1:0]  sh_reg;
    logic [15:0]       crc_reg;
    logic              accept;
    logic [7:0]        func_code;

    assign accept    = s_valid && s_ready;
    assign func_code = (s_kind == KIND_WRITE) ? FUNC_WRITE_SINGLE : FUNC_READ_HOLDING;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    state_next = FR_CRC;
                end
            end
            FR_CRC: begin
                if (step_reg == STEP_W'(CRC_BYTES - 1)) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (push_ready) begin
                    state_next = accept ? FR_CRC : FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            FR_IDLE: s_ready = 1'b1;
            FR_CRC:  s_ready = 1'b0;
            FR_PUSH: begin
                push_valid = 1'b1;
                s_ready    = push_ready;
            end
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hdr_reg  <= {slave_address, func_code, s_start_address, s_data_word};
            sh_reg   <= {slave_address, func_code, s_start_address, s_data_word};
            crc_reg  <= CRC_INIT;
            step_reg <= '0;
        end else if (state_reg == FR_CRC) begin
            crc_reg  <= crc16_byte(crc_reg, sh_reg[HDR_W-1 -: 8]);
            sh_reg   <= sh_reg << 8;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // CRC goes out low byte first
    assign push_frame = {hdr_reg, crc_reg[7:0], crc_reg[15:8]};

endmodule

// ----- rtl/mrhf_queue.sv -----
// Small frame queue between the front end and the character sender.
`include "modbus_request_hex_framer_assert.svh"

module mrhf_queue #(
    parameter int unsigned DEPTH = mrhf_pkg::QUEUE_DEPTH_D
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  mrhf_pkg::frame_t    push_frame,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mrhf_pkg::frame_t    pop_frame
);
    import mrhf_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    frame_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_frame  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `MRHF_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > CNT_W'(DEPTH))
    `MRHF_ASSERT(a_empty_ptrs, aclk, aresetn, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
    `MRHF_ASSERT(a_full_ptrs, aclk, aresetn, (count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
    `MRHF_ASSERT(a_push_grows, aclk, aresetn, (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + CNT_W'(1)))

endmodule

// ----- rtl/mrhf_back.sv -----
// Back end: turns each queued frame into sixteen hex characters.
module mrhf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  mrhf_pkg::frame_t    pop_frame,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [6:0]          m_hex_char,
    output logic                m_last
);
    import mrhf_pkg::*;

    frame_t                frame_reg;
    logic [CHAR_IDX_W-1:0] idx_reg;
    logic                  active_reg;
    logic                  m_valid_reg;
    logic [6:0]            hex_reg;
    logic                  last_reg;
    logic                  out_free;
    logic                  issue;
    logic                  at_last;
    logic                  finish;
    logic                  pop_fire;

    assign out_free  = !m_valid_reg || m_ready;
    assign issue     = active_reg && out_free;
    assign at_last   = (idx_reg == CHAR_IDX_W'(FRAME_CHARS - 1));
    assign finish    = issue && at_last;
    assign pop_ready = !active_reg || finish;
    assign pop_fire  = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop_fire) begin
                active_reg <= 1'b1;
            end else if (finish) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            hex_reg   <= nibble_ascii(frame_reg[FRAME_W-1 -: 4]);
            last_reg  <= at_last;
            frame_reg <= frame_reg << 4;
            idx_reg   <= idx_reg + CHAR_IDX_W'(1);
        end
        if (pop_fire) begin
            frame_reg <= pop_frame;
            idx_reg   <= '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hex_char = hex_reg;
    assign m_last     = last_reg;

endmodule

// ----- rtl/modbus_request_hex_framer.sv -----
// Top level of the Modbus RTU request framer with hex-text output.
// After CRC, push and queue, a request's first character leaves the output register.
// Sustained rate: one character per cycle on the output while m_ready stays high.
// The front end runs one CRC step per header byte, six in all, then a push state.
// Reset (synchronous, active low) empties the queue and sets the slave address to 0x11.
module modbus_request_hex_framer #(
    parameter int unsigned QUEUE_DEPTH = mrhf_pkg::QUEUE_DEPTH_D
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_start_address,
    input  logic [15:0] s_data_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_hex_char,
    output logic        m_last
);
    import mrhf_pkg::*;

    logic [7:0] slave_addr_reg;
    logic       push_valid;
    logic       push_ready;
    frame_t     push_frame;
    logic       pop_valid;
    logic       pop_ready;
    frame_t     pop_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
        end else if (cfg_wr_en) begin
            slave_addr_reg <= cfg_wr_data;
        end
    end

    mrhf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .slave_address   (slave_addr_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_start_address (s_start_address),
        .s_data_word     (s_data_word),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_frame      (push_frame)
    );

    mrhf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    mrhf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hex_char (m_hex_char),
        .m_last     (m_last)
    );

endmodule
